// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the convolution engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rstn, prop)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/cbr_pkg.sv
// ----------------------------------------------------------------------------
// cbr_pkg
// Types and constants shared by the convolution engine modules.
// ----------------------------------------------------------------------------
package cbr_pkg;

    localparam int CALC_W  = 20;   // address arithmetic width
    localparam int ACC_W   = 40;   // Q24.16 accumulator
    localparam int WORD_W  = 16;   // Q8.8 word
    localparam int PROD_W  = 32;
    localparam int VALUE_W = 15;
    localparam int INDEX_W = 14;

    localparam logic [1:0] REQ_IMAGE   = 2'd0;
    localparam logic [1:0] REQ_WEIGHT  = 2'd1;
    localparam logic [1:0] REQ_BIAS    = 2'd2;
    localparam logic [1:0] REQ_COMPUTE = 2'd3;

    localparam logic [2:0] CFG_IN_CHANNELS  = 3'd0;
    localparam logic [2:0] CFG_OUT_CHANNELS = 3'd1;
    localparam logic [2:0] CFG_IN_SIDE      = 3'd2;
    localparam logic [2:0] CFG_OUT_SIDE     = 3'd3;
    localparam logic [2:0] CFG_KERNEL_SIDE  = 3'd4;
    localparam logic [2:0] CFG_STEP         = 3'd5;
    localparam logic [2:0] CFG_PAD          = 3'd6;

    typedef struct packed {
        logic [4:0] in_channels;
        logic [4:0] out_channels;
        logic [5:0] in_side;
        logic [5:0] out_side;
        logic [2:0] kernel_side;
        logic [2:0] step;
        logic [1:0] pad;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [1:0]        sel;
        logic [CALC_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [CALC_W-1:0] ia;
        logic [CALC_W-1:0] wa;
    } rd_req_t;

    typedef struct packed {
        logic in_ready;
        logic acc_clear;
        logic result_load;
    } seq_ctl_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               sat;
    } result_t;

endpackage

// File: rtl/cbr_store.sv
// ----------------------------------------------------------------------------
// cbr_store
// Image, weight and bias memories with registered reads; out-of-range
// image and weight reads return zero.
// ----------------------------------------------------------------------------
module cbr_store #(
    parameter int IMAGE_WORDS      = 1024,
    parameter int WEIGHT_WORDS     = 1024,
    parameter int MAX_OUT_CHANNELS = 16
) (
    input  logic                                  aclk,
    input  cbr_pkg::store_wr_t                    wr,
    input  cbr_pkg::rd_req_t                      rd,
    input  logic [cbr_pkg::CALC_W-1:0]            bias_addr,
    output logic signed [cbr_pkg::WORD_W-1:0]     img_word,
    output logic signed [cbr_pkg::WORD_W-1:0]     wgt_word,
    output logic signed [cbr_pkg::WORD_W-1:0]     bias_word
);

    localparam int IMG_AW  = $clog2(IMAGE_WORDS);
    localparam int WGT_AW  = $clog2(WEIGHT_WORDS);
    localparam int BIAS_AW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

    logic [cbr_pkg::WORD_W-1:0] img_mem  [IMAGE_WORDS];
    logic [cbr_pkg::WORD_W-1:0] wgt_mem  [WEIGHT_WORDS];
    logic [cbr_pkg::WORD_W-1:0] bias_mem [MAX_OUT_CHANNELS];

    logic [cbr_pkg::WORD_W-1:0] img_data_reg;
    logic [cbr_pkg::WORD_W-1:0] wgt_data_reg;
    logic [cbr_pkg::WORD_W-1:0] bias_data_reg;
    logic                       img_ok_reg;
    logic                       wgt_ok_reg;

    logic wr_img_ok, wr_wgt_ok, wr_bias_ok;
    logic rd_img_ok, rd_wgt_ok, rd_bias_ok;

    assign wr_img_ok  = wr.addr < cbr_pkg::CALC_W'(IMAGE_WORDS);
    assign wr_wgt_ok  = wr.addr < cbr_pkg::CALC_W'(WEIGHT_WORDS);
    assign wr_bias_ok = wr.addr < cbr_pkg::CALC_W'(MAX_OUT_CHANNELS);
    assign rd_img_ok  = rd.ia < cbr_pkg::CALC_W'(IMAGE_WORDS);
    assign rd_wgt_ok  = rd.wa < cbr_pkg::CALC_W'(WEIGHT_WORDS);
    assign rd_bias_ok = bias_addr < cbr_pkg::CALC_W'(MAX_OUT_CHANNELS);

    always_ff @(posedge aclk) begin
        if (wr.en && wr.sel == cbr_pkg::REQ_IMAGE && wr_img_ok) begin
            img_mem[wr.addr[IMG_AW-1:0]] <= wr.data;
        end
        if (wr.en && wr.sel == cbr_pkg::REQ_WEIGHT && wr_wgt_ok) begin
            wgt_mem[wr.addr[WGT_AW-1:0]] <= wr.data;
        end
        if (wr.en && wr.sel == cbr_pkg::REQ_BIAS && wr_bias_ok) begin
            bias_mem[wr.addr[BIAS_AW-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        img_ok_reg <= rd.en && rd_img_ok;
        wgt_ok_reg <= rd.en && rd_wgt_ok;
        if (rd.en && rd_img_ok) begin
            img_data_reg <= img_mem[rd.ia[IMG_AW-1:0]];
        end
        if (rd.en && rd_wgt_ok) begin
            wgt_data_reg <= wgt_mem[rd.wa[WGT_AW-1:0]];
        end
        if (rd_bias_ok) begin
            bias_data_reg <= bias_mem[bias_addr[BIAS_AW-1:0]];
        end
    end

    assign img_word  = img_ok_reg ? signed'(img_data_reg) : '0;
    assign wgt_word  = wgt_ok_reg ? signed'(wgt_data_reg) : '0;
    assign bias_word = signed'(bias_data_reg);

endmodule

// File: rtl/cbr_mac.sv
// ----------------------------------------------------------------------------
// cbr_mac
// Shared multiply-accumulate unit with bias add, rectify and unsigned Q7.8 saturation.
// ----------------------------------------------------------------------------
module cbr_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              rd_issue,
    input  logic                              acc_clear,
    input  logic signed [cbr_pkg::WORD_W-1:0] img_word,
    input  logic signed [cbr_pkg::WORD_W-1:0] wgt_word,
    input  logic signed [cbr_pkg::WORD_W-1:0] bias_word,
    output logic                              busy,
    output cbr_pkg::result_t                  result
);

    localparam int ACC_W  = cbr_pkg::ACC_W;
    localparam int PROD_W = cbr_pkg::PROD_W;
    localparam int WORD_W = cbr_pkg::WORD_W;

    logic                     stage1_reg;
    logic                     stage2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         bias_term;
    logic [ACC_W-1:0]         sum;
    logic                     over;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
        end else begin
            stage1_reg <= rd_issue;
            stage2_reg <= stage1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= img_word * wgt_word;
        if (acc_clear) begin
            acc_reg <= '0;
        end else if (stage2_reg) begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // bias moves to Q24.16
    assign bias_term = {{(ACC_W-WORD_W-8){bias_word[WORD_W-1]}}, bias_word, 8'b0};
    assign sum       = acc_reg + bias_term;
    assign over      = |sum[ACC_W-2:cbr_pkg::VALUE_W+8];

    always_comb begin
        if (sum[ACC_W-1]) begin
            result.value = '0;
            result.sat   = 1'b0;
        end else if (over) begin
            result.value = '1;
            result.sat   = 1'b1;
        end else begin
            result.value = sum[cbr_pkg::VALUE_W+7:8];
            result.sat   = 1'b0;
        end
    end

    assign busy = stage1_reg || stage2_reg;

endmodule

// File: rtl/cbr_seq.sv
// ----------------------------------------------------------------------------
// cbr_seq
// Sequencer: takes requests, walks kernel taps and input channels, and
// generates store addresses for the shared MAC.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbr_seq #(
    parameter int MAX_OUT_CHANNELS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cbr_pkg::cfg_t                      cfg,
    input  logic                               s_valid,
    input  logic [1:0]                         req_type,
    input  logic [9:0]                         load_addr,
    input  logic [15:0]                        load_value,
    input  logic [4:0]                         out_row,
    input  logic [4:0]                         out_col,
    input  logic [3:0]                         out_chan,
    input  logic                               out_free,
    input  logic                               mac_busy,
    output cbr_pkg::seq_ctl_t                  ctl,
    output cbr_pkg::store_wr_t                 wr,
    output cbr_pkg::rd_req_t                   rd,
    output logic [cbr_pkg::CALC_W-1:0]         bias_addr,
    output logic [cbr_pkg::INDEX_W-1:0]        result_index
);

    localparam int CALC_W = cbr_pkg::CALC_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SET1  = 3'd1;
    localparam logic [2:0] ST_SET2  = 3'd2;
    localparam logic [2:0] ST_TAP   = 3'd3;
    localparam logic [2:0] ST_CHAN  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [3:0]         ochan_reg;
    logic [4:0]         ocol_reg;
    logic signed [9:0]  r0_reg, c0_reg;
    logic [11:0]        plane_reg;
    logic [5:0]         kk_reg;
    logic [11:0]        osq_reg;
    logic [10:0]        orow_os_reg;
    logic [8:0]         ocic_reg;
    logic [14:0]        wch_reg;
    logic [cbr_pkg::INDEX_W-1:0] index_reg;
    logic [2:0]         kr_reg, kc_reg;
    logic [4:0]         ic_reg;
    logic [CALC_W-1:0]  ia_reg, wa_reg;

    logic               accept, in_range, start;
    logic [7:0]         row_step, col_step;
    logic [11:0]        plane_full, osq_full;
    logic [5:0]         kk_full;
    logic [10:0]        orow_os_full;
    logic [8:0]         ocic_full;
    logic [16:0]        chan_off, index_full;
    logic [14:0]        wch_full;
    logic signed [9:0]  tap_r, tap_c;
    logic               tap_ok;
    logic [11:0]        row_off;
    logic [5:0]         kr_off;
    logic               kr_done, kc_last, ic_last;

    assign accept   = (state_reg == ST_IDLE) && s_valid;
    assign in_range = ({1'b0, out_chan} < cfg.out_channels)
                   && (CALC_W'(out_chan) < CALC_W'(MAX_OUT_CHANNELS))
                   && ({1'b0, out_row} < cfg.out_side)
                   && ({1'b0, out_col} < cfg.out_side);
    assign start    = accept && req_type == cbr_pkg::REQ_COMPUTE && in_range;

    assign row_step     = out_row * cfg.step;
    assign col_step     = out_col * cfg.step;
    assign plane_full   = cfg.in_side * cfg.in_side;
    assign osq_full     = cfg.out_side * cfg.out_side;
    assign kk_full      = cfg.kernel_side * cfg.kernel_side;
    assign orow_os_full = out_row * cfg.out_side;

    assign ocic_full  = ochan_reg * cfg.in_channels;
    assign chan_off   = ochan_reg * osq_reg;
    assign index_full = chan_off + 17'(orow_os_reg) + 17'(ocol_reg);
    assign wch_full   = ocic_reg * kk_reg;

    assign tap_r   = r0_reg + signed'({7'b0, kr_reg});
    assign tap_c   = c0_reg + signed'({7'b0, kc_reg});
    assign tap_ok  = !tap_r[9] && (tap_r[8:0] < 9'(cfg.in_side))
                  && !tap_c[9] && (tap_c[8:0] < 9'(cfg.in_side))
                  && (cfg.in_channels != 5'd0);
    assign row_off = tap_r[5:0] * cfg.in_side;
    assign kr_off  = kr_reg * cfg.kernel_side;

    assign kr_done = kr_reg >= cfg.kernel_side;
    assign kc_last = kc_reg == cfg.kernel_side - 3'd1;
    assign ic_last = ic_reg == cfg.in_channels - 5'd1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_SET1;
            ST_SET1:  state_next = ST_SET2;
            ST_SET2:  state_next = ST_TAP;
            ST_TAP: begin
                if (kr_done) begin
                    state_next = ST_DRAIN;
                end else if (tap_ok) begin
                    state_next = ST_CHAN;
                end
            end
            ST_CHAN:  if (ic_last) state_next = ST_TAP;
            ST_DRAIN: if (!mac_busy) state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    ochan_reg   <= out_chan;
                    ocol_reg    <= out_col;
                    r0_reg      <= signed'(10'(row_step) - 10'(cfg.pad));
                    c0_reg      <= signed'(10'(col_step) - 10'(cfg.pad));
                    plane_reg   <= plane_full;
                    kk_reg      <= kk_full;
                    osq_reg     <= osq_full;
                    orow_os_reg <= orow_os_full;
                end
            end
            ST_SET1: begin
                ocic_reg  <= ocic_full;
                index_reg <= index_full[cbr_pkg::INDEX_W-1:0];
            end
            ST_SET2: begin
                wch_reg <= wch_full;
                kr_reg  <= '0;
                kc_reg  <= '0;
            end
            ST_TAP: begin
                if (!kr_done) begin
                    if (tap_ok) begin
                        ia_reg <= CALC_W'(row_off) + CALC_W'(tap_c[5:0]);
                        wa_reg <= CALC_W'(wch_reg) + CALC_W'(kr_off) + CALC_W'(kc_reg);
                        ic_reg <= '0;
                    end else if (kc_last) begin
                        kc_reg <= '0;
                        kr_reg <= kr_reg + 3'd1;
                    end else begin
                        kc_reg <= kc_reg + 3'd1;
                    end
                end
            end
            ST_CHAN: begin
                ia_reg <= ia_reg + CALC_W'(plane_reg);
                wa_reg <= wa_reg + CALC_W'(kk_reg);
                ic_reg <= ic_reg + 5'd1;
                if (ic_last) begin
                    if (kc_last) begin
                        kc_reg <= '0;
                        kr_reg <= kr_reg + 3'd1;
                    end else begin
                        kc_reg <= kc_reg + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign ctl.in_ready    = state_reg == ST_IDLE;
    assign ctl.acc_clear   = state_reg == ST_SET1;
    assign ctl.result_load = (state_reg == ST_FIN) && out_free;

    assign wr.en   = accept && req_type != cbr_pkg::REQ_COMPUTE;
    assign wr.sel  = req_type;
    assign wr.addr = CALC_W'(load_addr);
    assign wr.data = load_value;

    assign rd.en = state_reg == ST_CHAN;
    assign rd.ia = ia_reg;
    assign rd.wa = wa_reg;

    assign bias_addr    = CALC_W'(ochan_reg);
    assign result_index = index_reg;

    `ASSERT_HOLDS(a_chan_bounds, aclk, aresetn, state_reg == ST_CHAN |-> (kr_reg < cfg.kernel_side && kc_reg < cfg.kernel_side && ic_reg < cfg.in_channels))
    `ASSERT_HOLDS(a_fin_drained, aclk, aresetn, state_reg == ST_FIN |-> !mac_busy)
    `ASSERT_NEXT(a_load_stays_idle, aclk, aresetn, accept && req_type != cbr_pkg::REQ_COMPUTE, state_reg == ST_IDLE)

endmodule

// File: rtl/conv2d_bias_relu.sv
// ----------------------------------------------------------------------------
// conv2d_bias_relu
// Multi-channel 2D convolution with bias and rectification for one image.
// Load words write the image, weight and bias memories. A compute word runs
// through a single shared 16x16 multiply-accumulate unit, one product per cycle
// while it walks the input channels of a tap; products are formed only for
// window taps that fall inside the image. The input and the configuration
// port are not ready while a compute word is in progress.
// Result words pass through an output register.
// ----------------------------------------------------------------------------
module conv2d_bias_relu #(
    parameter int IMAGE_WORDS      = 1024,
    parameter int WEIGHT_WORDS     = 1024,
    parameter int MAX_OUT_CHANNELS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // load_addr, load_value, out_row, out_col, out_chan
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_value, result_index, zero fill
    output logic [0:0]  m_tuser,   // saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int OUT_FILL = 32 - cbr_pkg::VALUE_W - cbr_pkg::INDEX_W;

    cbr_pkg::cfg_t      cfg_reg;
    cbr_pkg::seq_ctl_t  ctl;
    cbr_pkg::store_wr_t wr;
    cbr_pkg::rd_req_t   rd;
    cbr_pkg::result_t   result;

    logic [cbr_pkg::CALC_W-1:0]        bias_addr;
    logic [cbr_pkg::INDEX_W-1:0]       result_index;
    logic signed [cbr_pkg::WORD_W-1:0] img_word, wgt_word, bias_word;
    logic                              mac_busy;
    logic                              out_free;

    logic                         m_valid_reg;
    logic [cbr_pkg::VALUE_W-1:0]  m_value_reg;
    logic [cbr_pkg::INDEX_W-1:0]  m_index_reg;
    logic                         m_sat_reg;

    assign cfg_ready = ctl.in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_channels  <= 5'd1;
            cfg_reg.out_channels <= 5'd1;
            cfg_reg.in_side      <= 6'd8;
            cfg_reg.out_side     <= 6'd8;
            cfg_reg.kernel_side  <= 3'd3;
            cfg_reg.step         <= 3'd1;
            cfg_reg.pad          <= 2'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cbr_pkg::CFG_IN_CHANNELS:  cfg_reg.in_channels  <= cfg_data[4:0];
                cbr_pkg::CFG_OUT_CHANNELS: cfg_reg.out_channels <= cfg_data[4:0];
                cbr_pkg::CFG_IN_SIDE:      cfg_reg.in_side      <= cfg_data;
                cbr_pkg::CFG_OUT_SIDE:     cfg_reg.out_side     <= cfg_data;
                cbr_pkg::CFG_KERNEL_SIDE:  cfg_reg.kernel_side  <= cfg_data[2:0];
                cbr_pkg::CFG_STEP:         cfg_reg.step         <= cfg_data[2:0];
                cbr_pkg::CFG_PAD:          cfg_reg.pad          <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    cbr_seq #(
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_tvalid),
        .req_type     (s_tuser),
        .load_addr    (s_tdata[9:0]),
        .load_value   (s_tdata[25:10]),
        .out_row      (s_tdata[30:26]),
        .out_col      (s_tdata[35:31]),
        .out_chan     (s_tdata[39:36]),
        .out_free     (out_free),
        .mac_busy     (mac_busy),
        .ctl          (ctl),
        .wr           (wr),
        .rd           (rd),
        .bias_addr    (bias_addr),
        .result_index (result_index)
    );

    cbr_store #(
        .IMAGE_WORDS      (IMAGE_WORDS),
        .WEIGHT_WORDS     (WEIGHT_WORDS),
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
    ) u_store (
        .aclk      (aclk),
        .wr        (wr),
        .rd        (rd),
        .bias_addr (bias_addr),
        .img_word  (img_word),
        .wgt_word  (wgt_word),
        .bias_word (bias_word)
    );

    cbr_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_issue  (rd.en),
        .acc_clear (ctl.acc_clear),
        .img_word  (img_word),
        .wgt_word  (wgt_word),
        .bias_word (bias_word),
        .busy      (mac_busy),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.result_load) begin
            m_value_reg <= result.value;
            m_index_reg <= result_index;
            m_sat_reg   <= result.sat;
        end
    end

    assign s_tready = ctl.in_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_FILL{1'b0}}, m_index_reg, m_value_reg};
    assign m_tuser  = m_sat_reg;

endmodule
